// ----- hdl/itrt_pkg.sv -----
// itrt_pkg: shared widths, result codes, command/status structs and the
// digit-to-character function for the integer to radix text converter
// no dependencies

package itrt_pkg;

    // field widths
    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 6;
    localparam int BSZ_W    = 7;
    localparam int CHAR_W   = 7;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 6;

    // long division: quotient bits resolved per cycle
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    // limits and reset values
    localparam int DEFAULT_MAX_DIGITS = 64;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd62;
    localparam logic [BSZ_W-1:0]   BSZ_RESET = 7'd65;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DIGIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic start_conv;       // load value and radix, clear digit count
        logic take_special;     // latch rejected / empty code
        logic div_step;         // one long-division step
        logic rd_issue;         // read digit store at current read index
        logic out_load_digit;   // load output register with a digit
        logic out_load_special; // load output register with special code
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic arg_reject;   // radix or buffer size rejected
        logic arg_empty;    // buffer holds only the terminator
        logic div_last;     // last cycle of the current digit
        logic conv_more;    // another digit follows this one
        logic rd_last;      // read index at least significant end
        logic out_free;     // output register can take a result
    } stat_t;

    // digit value to ascii: 0-9, A-Z, a-z
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] ch;
        dx = {1'b0, d};
        if (d < 6'd10)
            ch = 7'd48 + dx;
        else if (d < 6'd36)
            ch = 7'd55 + dx;
        else if (d < 6'd62)
            ch = 7'd61 + dx;
        else
            ch = '0;
        return ch;
    endfunction

endpackage

// ----- hdl/integer_to_radix_text.sv -----
// integer_to_radix_text: top level joining the controller and the datapath
// depends on itrt_pkg, itrt_ctrl, itrt_dp (and through it itrt_ram)
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in       | input     | in_valid / in_stall  | value, radix
//  out      | output    | out_valid / out_stall| digit_char, last, status
//  cfg      | input     | cfg_valid / cfg_ready| cfg_data (buffer_size)
//
// each digit is worked out by the long divider (8 quotient bits a cycle
// over the 64-bit value); the digits then leave, most significant first,
// through the digit store's registered read port
// rejected and empty-string items bypass the divider and the digit store
// reset clears control state and sets buffer_size to 65; no clearing pass
// output stalls hold the emit sequence; the input is stalled until the last
// result of the item is in the output register

module integer_to_radix_text #(
    parameter int MAX_DIGITS = itrt_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [itrt_pkg::VALUE_W-1:0]     value,
    input  logic [itrt_pkg::RADIX_W-1:0]     radix,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [itrt_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last,
    output logic [itrt_pkg::STATUS_W-1:0]    status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [itrt_pkg::BSZ_W-1:0]       cfg_data
);

    import itrt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    itrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    itrt_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .value      (value),
        .radix      (radix),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .status     (status)
    );

    // an accepted item closes the input until it is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transfer");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load_digit || cmd.out_load_special) |-> stat.out_free)
        else $error("output register loaded while occupied");

    // dividing and emitting never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_step && (cmd.rd_issue || cmd.out_load_digit)))
        else $error("divider and emit sequence active together");

endmodule

// ----- hdl/itrt_ram.sv -----
// itrt_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module itrt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/itrt_ctrl.sv -----
// itrt_ctrl: sequencing state machine for the converter
// depends on itrt_pkg (cmd_t, stat_t)

module itrt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  itrt_pkg::stat_t stat,
    output itrt_pkg::cmd_t  cmd
);

    import itrt_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIVIDE  = 3'd1;
    localparam logic [2:0] S_EMIT_RD = 3'd2;
    localparam logic [2:0] S_EMIT_LD = 3'd3;
    localparam logic [2:0] S_SPECIAL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // input side open only between conversions
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.arg_reject || stat.arg_empty)
                    begin
                        cmd.take_special = 1'b1;
                        state_next       = S_SPECIAL;
                    end
                    else
                    begin
                        cmd.start_conv = 1'b1;
                        state_next     = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last && !stat.conv_more)
                    state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load_digit = 1'b1;
                    state_next         = stat.rd_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_SPECIAL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load_special = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hdl/itrt_dp.sv -----
// itrt_dp: datapath with buffer size register, long divider, digit store
// and output register; depends on itrt_pkg and itrt_ram

module itrt_dp #(
    parameter int MAX_DIGITS = itrt_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  itrt_pkg::cmd_t                   cmd,
    output itrt_pkg::stat_t                  stat,
    input  logic [itrt_pkg::VALUE_W-1:0]     value,
    input  logic [itrt_pkg::RADIX_W-1:0]     radix,
    input  logic                             cfg_valid,
    input  logic [itrt_pkg::BSZ_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [itrt_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last,
    output logic [itrt_pkg::STATUS_W-1:0]    status
);

    import itrt_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    logic [BSZ_W-1:0]     bsz_reg;
    logic [VALUE_W-1:0]   quot_reg;
    logic [VALUE_W-1:0]   quot_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_inc;
    logic [CNT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]     limit_next;
    logic [BSZ_W-1:0]     bsz_less;
    logic [ADDR_W-1:0]    rd_idx_reg;
    logic [STATUS_W-1:0]  spec_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [DIGIT_W-1:0]   ram_rdata;
    logic                 digit_wr;

    // argument checks on the offered item
    assign stat.arg_reject = (radix == '0) || (radix > RADIX_MAX) || (bsz_reg == '0);
    assign stat.arg_empty  = (bsz_reg == 7'd1);

    // digit limit: buffer size less one, saturated at the store depth
    assign bsz_less   = bsz_reg - 7'd1;
    assign limit_next = (bsz_less > BSZ_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                        : CNT_W'(bsz_less);

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        logic [DIGIT_W:0]          trial;
        logic [DIGIT_W-1:0]        r;
        logic [BITS_PER_CYCLE-1:0] qb;
        r  = rem_reg;
        qb = '0;
        for (int k = 0; k < BITS_PER_CYCLE; k++)
        begin
            trial = {r, quot_reg[VALUE_W-1-k]};
            if (trial >= {1'b0, radix_reg})
            begin
                r                       = DIGIT_W'(trial - {1'b0, radix_reg});
                qb[BITS_PER_CYCLE-1-k]  = 1'b1;
            end
            else
            begin
                r = trial[DIGIT_W-1:0];
            end
        end
        rem_next  = r;
        quot_next = {quot_reg[VALUE_W-BITS_PER_CYCLE-1:0], qb};
    end

    assign count_inc      = count_reg + CNT_W'(1);
    assign stat.div_last  = (step_reg == DIV_CNT_W'(DIV_CYCLES - 1));
    assign stat.conv_more = (count_inc < limit_reg) && (quot_next != '0);
    assign stat.rd_last   = (rd_idx_reg == '0);
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign digit_wr       = cmd.div_step && stat.div_last;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bsz_reg <= BSZ_RESET;
        else if (cfg_valid)
            bsz_reg <= cfg_data;
    end

    // divider and digit counting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg  <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.start_conv)
        begin
            quot_reg  <= value;
            rem_reg   <= '0;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            step_reg <= step_reg + DIV_CNT_W'(1);
            if (stat.div_last)
            begin
                rem_reg   <= '0;
                count_reg <= count_inc;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
    end

    // conversion arguments, special code and read index
    always_ff @(posedge clk)
    begin
        if (cmd.start_conv)
        begin
            radix_reg <= radix;
            limit_reg <= limit_next;
        end
        if (cmd.take_special)
            spec_reg <= stat.arg_reject ? ST_REJECT : ST_EMPTY;
        if (digit_wr && !stat.conv_more)
            rd_idx_reg <= count_reg[ADDR_W-1:0];
        else if (cmd.out_load_digit && !stat.rd_last)
            rd_idx_reg <= rd_idx_reg - ADDR_W'(1);
    end

    // digit store
    itrt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (digit_wr),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rem_next),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load_digit || cmd.out_load_special)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_digit)
        begin
            char_reg   <= digit_to_char(ram_rdata);
            last_reg   <= stat.rd_last;
            status_reg <= ST_DIGIT;
        end
        else if (cmd.out_load_special)
        begin
            char_reg   <= '0;
            last_reg   <= 1'b1;
            status_reg <= spec_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;
    assign status     = status_reg;

endmodule

// ----- tb/integer_to_radix_text_checker.sv -----
// integer_to_radix_text_checker: watches the config, input and output channels,
// predicts the digit text of every accepted conversion and compares each result
// depends on itrt_pkg

module integer_to_radix_text_checker #(
    parameter int MAX_DIGITS = itrt_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [itrt_pkg::VALUE_W-1:0]     value,
    input  logic [itrt_pkg::RADIX_W-1:0]     radix,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [itrt_pkg::CHAR_W-1:0]      digit_char,
    input  logic                             last,
    input  logic [itrt_pkg::STATUS_W-1:0]    status,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [itrt_pkg::BSZ_W-1:0]       cfg_data,
    output int                               mismatch_count,
    output int                               pending_count,
    output int                               result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // keeps the log readable when the block is badly broken
    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic [itrt_pkg::CHAR_W-1:0]   digit_char;
        logic                          last;
        logic [itrt_pkg::STATUS_W-1:0] status;
    } text_result_t;

    text_result_t                  expected_text[$];

    // predictor copy of the register and the conversion state
    logic [itrt_pkg::BSZ_W-1:0]    buffer_size_q;
    logic [itrt_pkg::VALUE_W-1:0]  quotient_q;
    logic [itrt_pkg::DIGIT_W-1:0]  digit_q [64];
    int                            digit_cnt_q;

    // digit value to its character: decimal, then upper case, then lower case
    function automatic logic [itrt_pkg::CHAR_W-1:0] char_of_digit(
        input logic [itrt_pkg::DIGIT_W-1:0] d
    );
        int dv;
        dv = int'(d);
        if (dv <= 9)
            return 7'(int'("0") + dv);
        else if (dv <= 35)
            return 7'(int'("A") + dv - 10);
        else if (dv <= 61)
            return 7'(int'("a") + dv - 36);
        return '0;
    endfunction

    task automatic push_result(
        input logic [itrt_pkg::CHAR_W-1:0]   ch,
        input logic                          lst,
        input logic [itrt_pkg::STATUS_W-1:0] st
    );
        text_result_t r;
        r.digit_char = ch;
        r.last       = lst;
        r.status     = st;
        expected_text.push_back(r);
    endtask

    // repeated division, least significant digit first, then emitted reversed
    task automatic predict_conversion(
        input logic [itrt_pkg::VALUE_W-1:0] v,
        input logic [itrt_pkg::RADIX_W-1:0] r
    );
        int lim;
        int k;
        if (r == '0 || r > itrt_pkg::RADIX_MAX || buffer_size_q == '0) begin
            push_result('0, 1'b1, itrt_pkg::ST_REJECT);
        end
        else if (buffer_size_q == 7'd1) begin
            push_result('0, 1'b1, itrt_pkg::ST_EMPTY);
        end
        else begin
            lim = int'(buffer_size_q) - 1;
            if (lim > MAX_DIGITS)
                lim = MAX_DIGITS;
            quotient_q  = v;
            digit_q[0]  = itrt_pkg::DIGIT_W'(quotient_q % r);
            quotient_q  = quotient_q / r;
            digit_cnt_q = 1;
            while (digit_cnt_q < lim && quotient_q != '0) begin
                digit_q[digit_cnt_q] = itrt_pkg::DIGIT_W'(quotient_q % r);
                quotient_q           = quotient_q / r;
                digit_cnt_q++;
            end
            for (k = digit_cnt_q - 1; k >= 0; k--)
                push_result(char_of_digit(digit_q[k]), k == 0, itrt_pkg::ST_DIGIT);
        end
    endtask

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    // channel monitor: output compare first, so a stray result is never masked
    always @(posedge clk or negedge rst_n)
    begin
        text_result_t want;
        if (!rst_n)
        begin
            expected_text.delete();
            buffer_size_q  = itrt_pkg::BSZ_RESET;
            quotient_q     = '0;
            digit_cnt_q    = 0;
            mismatch_count = 0;
            result_count   = 0;
        end
        else
        begin
            // result transfer
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_text.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $error("result with nothing pending: digit_char %0d last %0d status %0d",
                               digit_char, last, status);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (digit_char !== want.digit_char)
                        report_field("digit_char", 8'(want.digit_char), 8'(digit_char));
                    if (last !== want.last)
                        report_field("last", 8'(want.last), 8'(last));
                    if (status !== want.status)
                        report_field("status", 8'(want.status), 8'(status));
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
                buffer_size_q = cfg_data;
            // input transfer
            if (in_valid && !in_stall)
                predict_conversion(value, radix);
        end
        pending_count = expected_text.size();
    end

endmodule

// ----- tb/integer_to_radix_text_tb.sv -----
// integer_to_radix_text_tb: drives conversions and buffer_size writes into the
// converter under three idling mixes and gives the verdict
// depends on itrt_pkg, integer_to_radix_text and integer_to_radix_text_checker

module integer_to_radix_text_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS      = itrt_pkg::DEFAULT_MAX_DIGITS;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int MIXES           = 3;
    localparam int BLOCKS_PER_MIX  = 4;
    localparam int ITEMS_PER_BLOCK = 25;
    localparam int TAIL_CYCLES     = 40;
    localparam logic [itrt_pkg::VALUE_W-1:0] ALL_ONES = '1;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [itrt_pkg::VALUE_W-1:0]    value     = '0;
    logic [itrt_pkg::RADIX_W-1:0]    radix     = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [itrt_pkg::CHAR_W-1:0]     digit_char;
    logic                            last;
    logic [itrt_pkg::STATUS_W-1:0]   status;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [itrt_pkg::BSZ_W-1:0]      cfg_data  = '0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent    = 0;
    int          directed_sent = 0;
    int          cfg_writes    = 0;
    int unsigned cycle_count   = 0;
    int          mismatch_count;
    int          pending_count;
    int          result_count;

    integer_to_radix_text #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    integer_to_radix_text_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .radix          (radix),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digit_char     (digit_char),
        .last           (last),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    // clock
    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one input transfer; valid stays high so back-to-back items need no gap
    task automatic send_conversion(input logic [itrt_pkg::VALUE_W-1:0] v,
                                   input logic [itrt_pkg::RADIX_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        radix    <= r;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // sender holds off until every predicted result has been taken
    task automatic wait_text_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // register write, only once the block has gone quiet
    task automatic write_buffer_size(input logic [itrt_pkg::BSZ_W-1:0] bsz);
        wait_text_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= bsz;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // mostly full-width values, some shortened, some at the ends of the range
    function automatic logic [itrt_pkg::VALUE_W-1:0] random_value();
        logic [itrt_pkg::VALUE_W-1:0] v;
        int unsigned                  k;
        v = {$urandom, $urandom};
        k = $urandom_range(99);
        if (k < 35)
            v = v >> $urandom_range(63);
        else if (k < 40)
            v = '0;
        else if (k < 45)
            v = ALL_ONES - $urandom_range(3);
        return v;
    endfunction

    // mostly legal bases, small ones favoured for long digit strings
    function automatic logic [itrt_pkg::RADIX_W-1:0] random_radix();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 3)
            return '0;
        else if (k < 6)
            return '1;
        else if (k < 9)
            return 6'd1;
        else if (k < 40)
            return itrt_pkg::RADIX_W'($urandom_range(16, 2));
        return itrt_pkg::RADIX_W'($urandom_range(62, 2));
    endfunction

    // buffer sizes: mostly usable, some saturating, a few degenerate
    function automatic logic [itrt_pkg::BSZ_W-1:0] random_buffer_size();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 5)
            return itrt_pkg::BSZ_W'($urandom_range(1));
        else if (k < 25)
            return itrt_pkg::BSZ_W'($urandom_range(127, 65));
        return itrt_pkg::BSZ_W'($urandom_range(64, 2));
    endfunction

    // stimulus and verdict
    initial
    begin
        send_idle_pct = 19;
        recv_idle_pct = 74;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset buffer size gives the full 64 digit limit
        send_conversion(64'd0, 6'd10);
        send_conversion(ALL_ONES, 6'd2);
        send_conversion(ALL_ONES, 6'd62);
        send_conversion(ALL_ONES, 6'd10);
        send_conversion(ALL_ONES, 6'd16);
        send_conversion(64'h0123_4567_89AB_CDEF, 6'd36);
        // table boundaries: 'Z', 'a', 'z', then '9', 'A'
        send_conversion(64'd136833, 6'd62);
        send_conversion(64'd568, 6'd62);
        // bad radix at both ends
        send_conversion(64'd5, 6'd0);
        send_conversion(ALL_ONES, 6'd63);
        // radix one: single zero for a zero value, else zeros up to the limit; then the top bit alone in base 2
        send_conversion(64'd0, 6'd1);
        send_conversion(64'd7, 6'd1);
        send_conversion(64'h8000_0000_0000_0000, 6'd2);
        // zero buffer rejects
        write_buffer_size(7'd0);
        send_conversion(64'd123, 6'd10);
        // unit buffer: empty string, but a bad radix still rejects
        write_buffer_size(7'd1);
        send_conversion(64'd123, 6'd10);
        send_conversion(64'd123, 6'd0);
        // one digit kept: the least significant one
        write_buffer_size(7'd2);
        send_conversion(ALL_ONES, 6'd10);
        // oversized buffers saturate at the digit limit
        write_buffer_size(7'd127);
        send_conversion(ALL_ONES, 6'd2);
        send_conversion(64'd3, 6'd1);
        write_buffer_size(7'd66);
        send_conversion(ALL_ONES, 6'd2);
        // truncated to the low digits
        write_buffer_size(7'd5);
        send_conversion(64'd12345678, 6'd10);
        send_conversion(64'd0, 6'd7);
        directed_sent = items_sent;

        // random: three idling mixes, a fresh buffer size per block
        for (int mix = 0; mix < MIXES; mix++)
        begin
            if (mix == 1)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 19;
            end
            else if (mix == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int blk = 0; blk < BLOCKS_PER_MIX; blk++)
            begin
                write_buffer_size(random_buffer_size());
                for (int n = 0; n < ITEMS_PER_BLOCK; n++)
                begin
                    if (n == ITEMS_PER_BLOCK / 2)
                        wait_text_drained();
                    send_conversion(random_value(), random_radix());
                end
            end
        end

        // drain, then watch for stray results
        wait_text_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d conversions (%0d directed), %0d result transfers checked,",
                 items_sent, directed_sent, result_count);
        $display("%0d buffer_size writes, three sender/receiver idling mixes",
                 cfg_writes);
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
